// ----- design/utf8_to_utf16_console_decoder_defines.svh -----
// Assertion macros for the UTF-8 to UTF-16 console decoder.
`ifndef UTF8_TO_UTF16_CONSOLE_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_CONSOLE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define U8U16_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("u8u16 assertion failed");
`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("u8u16 forbidden condition seen");
`else
`define U8U16_ASSERT(lbl, clk, rst_n, prop)
`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- design/u8u16_pkg.sv -----
// Shared constants and types of the UTF-8 to UTF-16 console decoder.
package u8u16_pkg;

	localparam int Q_DEPTH = 2;

	localparam logic [15:0] UNIT_INVALID = 16'hFFFE;
	localparam logic [15:0] UNIT_ZWNBSP  = 16'hFEFF;
	localparam logic [15:0] UNIT_QMARK   = 16'h003F;
	localparam logic [15:0] UNIT_LF      = 16'h000A;
	localparam logic [15:0] UNIT_CR      = 16'h000D;

	localparam logic [7:0] LEAD_MIN  = 8'hC2;
	localparam logic [7:0] LEAD_MAX  = 8'hEF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;

	typedef struct packed {
		logic [15:0] unit;
		logic        nl;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_port_t;

endpackage

// ----- design/u8u16_byte_if.sv -----
// Byte input channel: valid/ready handshake carrying one UTF-8 byte.
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ----- design/u8u16_unit_if.sv -----
// Code unit output channel: valid/ready handshake carrying one UTF-16 unit.
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last;

	modport source (output valid, output code_unit, output last, input ready);
	modport sink (input valid, input code_unit, input last, output ready);
endinterface

// ----- design/utf8_to_utf16_console_decoder.sv -----
// Top level of the UTF-8 to UTF-16 console decoder.
//
// bytes: valid/ready channel of UTF-8 bytes, one item per cycle while the queue is not full.
// units: valid/ready channel of 16-bit console code units with a last flag
//        that marks the final unit caused by one byte.
// A byte accepted on bytes enters the queue, then moves into the back end's
// output register, from which its first unit shows on units; a stall on
// units can hold it in the queue.
// Sustained rate is one byte per cycle while the queue has space. A newline
// yields CR (last low), then LF, through the single output register.
// With the default two-entry queue, each newline in a gapless stream fills
// the queue and stalls bytes; an idle input cycle absorbs it instead.
// Lead bytes, the middle byte of a three-byte form and a decoded U+FEFF
// produce no unit. Invalid input and a decoded U+FFFE produce '?'.
// When units stalls, the output holds its unit, the queue fills, and then
// bytes.ready drops until space frees up.
// Reset clears the pending sequence, the queue and the output valid; the
// block accepts bytes as soon as reset is released.
module utf8_to_utf16_console_decoder #(
	parameter int Q_DEPTH = u8u16_pkg::Q_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   bytes,
	u8u16_unit_if.source units
);
	import u8u16_pkg::*;

	q_port_t push, head;
	logic    q_full, pop;

	u8u16_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.q_full (q_full),
		.push   (push)
	);

	u8u16_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	u8u16_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.units  (units)
	);
endmodule

// ----- design/u8u16_front.sv -----
// Front end: accepts bytes, tracks the pending sequence, decodes units.
`include "utf8_to_utf16_console_decoder_defines.svh"
module u8u16_front (
	input  logic               clk,
	input  logic               arst_n,
	u8u16_byte_if.sink         bytes,
	input  logic               q_full,
	output u8u16_pkg::q_port_t push
);
	import u8u16_pkg::*;

	logic [7:0]  lead_q, mid_q;
	logic [7:0]  lead_d, mid_d;
	logic [15:0] unit_raw, unit_fix;
	logic [7:0]  b;
	logic        accept;

	assign b           = bytes.in_byte;
	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;

	always_comb begin
		unit_raw = UNIT_INVALID;
		lead_d   = lead_q;
		mid_d    = mid_q;
		if (!b[7]) begin
			if (lead_q == 8'h00) begin
				unit_raw = {8'h00, b};
			end else begin
				lead_d = 8'h00;
				mid_d  = 8'h00;
			end
		end else if (!b[6]) begin
			if (lead_q != 8'h00) begin
				if (lead_q < LEAD3_MIN) begin
					unit_raw = {5'b0, lead_q[4:0], b[5:0]};
					lead_d   = 8'h00;
					mid_d    = 8'h00;
				end else if (mid_q == 8'h00) begin
					mid_d    = b;
					unit_raw = UNIT_ZWNBSP;
				end else begin
					unit_raw = {lead_q[3:0], mid_q[5:0], b[5:0]};
					lead_d   = 8'h00;
					mid_d    = 8'h00;
				end
			end
		end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
			lead_d   = b;
			mid_d    = 8'h00;
			unit_raw = UNIT_ZWNBSP;
		end else begin
			lead_d = 8'h00;
			mid_d  = 8'h00;
		end
		unit_fix = (unit_raw == UNIT_INVALID) ? UNIT_QMARK : unit_raw;
	end

	assign push.valid      = accept && (unit_fix != UNIT_ZWNBSP);
	assign push.entry.unit = unit_fix;
	assign push.entry.nl   = (unit_fix == UNIT_LF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'h00;
			mid_q  <= 8'h00;
		end else if (accept) begin
			lead_q <= lead_d;
			mid_q  <= mid_d;
		end
	end

	`U8U16_ASSERT(a_lead_range, clk, arst_n,
		(lead_q == 8'h00) || (lead_q >= LEAD_MIN && lead_q <= LEAD_MAX))
	`U8U16_ASSERT(a_mid_needs_3byte_lead, clk, arst_n,
		(mid_q != 8'h00) |-> (lead_q >= LEAD3_MIN && mid_q[7:6] == 2'b10))
endmodule

// ----- design/u8u16_queue.sv -----
// Short FIFO between the decode front end and the output back end.
`include "utf8_to_utf16_console_decoder_defines.svh"
module u8u16_queue #(
	parameter int DEPTH = u8u16_pkg::Q_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  u8u16_pkg::q_port_t push,
	output logic               full,
	output u8u16_pkg::q_port_t head,
	input  logic               pop
);
	import u8u16_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;
	assign head.valid = (count_q != '0);
	assign head.entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`U8U16_ASSERT_NEVER(a_push_when_full, clk, arst_n, push.valid && full)
	`U8U16_ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && !head.valid)
endmodule

// ----- design/u8u16_back.sv -----
// Back end: drains queued units into the output register, splitting newline into CR LF.
`include "utf8_to_utf16_console_decoder_defines.svh"
module u8u16_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u8u16_pkg::q_port_t head,
	output logic               pop,
	u8u16_unit_if.source       units
);
	import u8u16_pkg::*;

	logic        valid_q, cr_sent_q, last_q;
	logic [15:0] unit_q;
	logic        load, first_of_nl;

	assign load        = !valid_q || units.ready;
	assign first_of_nl = head.entry.nl && !cr_sent_q;
	assign pop         = load && head.valid && !first_of_nl;

	assign units.valid     = valid_q;
	assign units.code_unit = unit_q;
	assign units.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			cr_sent_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				cr_sent_q <= first_of_nl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			if (first_of_nl) begin
				unit_q <= UNIT_CR;
				last_q <= 1'b0;
			end else begin
				unit_q <= head.entry.unit;
				last_q <= 1'b1;
			end
		end
	end

	`U8U16_ASSERT(a_not_last_is_cr, clk, arst_n,
		(valid_q && !last_q) |-> (unit_q == UNIT_CR))
	`U8U16_ASSERT(a_cr_then_lf, clk, arst_n,
		(valid_q && units.ready && !last_q) |=> (valid_q && last_q && unit_q == UNIT_LF))
endmodule

// ----- tb/utf8_to_utf16_console_decoder_tb.sv -----
// Self-checking testbench: random and edge-case UTF-8 streams, units checked against a predictor.
module utf8_to_utf16_console_decoder_tb;
	import u8u16_pkg::*;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last;
	} console_unit_t;

	logic clk;
	logic arst_n;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_console_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	logic [7:0]    text_bytes[$];
	console_unit_t expected_units[$];

	logic [7:0] edge_text[$] = '{
		8'h00, 8'h7F, 8'h0A, 8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF0, 8'hFF,
		8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h8A,
		8'hEF, 8'hBF, 8'hBE, 8'hEF, 8'hBB, 8'hBF,
		8'hC3, 8'h41, 8'hC3, 8'hE2, 8'h82, 8'hAC, 8'hE4, 8'hF5
	};

	logic [7:0] lead_q;
	logic [7:0] mid_q;

	int error_count;
	int bytes_queued;
	int bytes_sent;
	int units_seen;
	int input_stalls;
	int burst_left;
	int gap_left;
	int hold_cnt;
	int cyc;
	bit long_hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		error_count++;
	endtask

	task automatic push_unit(input logic [15:0] cu, input logic lst);
		console_unit_t u;
		u.code_unit = cu;
		u.last      = lst;
		expected_units.push_back(u);
	endtask

	// Decode one accepted byte, update pending state, queue the units it yields
	task automatic decode_byte(input logic [7:0] b);
		logic [15:0] cu;
		cu = UNIT_INVALID;
		if (b < 8'h80) begin
			if (lead_q == 8'h00) begin
				cu = {8'h00, b};
			end else begin
				lead_q = 8'h00;
				mid_q  = 8'h00;
			end
		end else if (b < 8'hC0) begin
			if (lead_q == 8'h00) begin
				cu = UNIT_INVALID;
			end else if (lead_q < LEAD3_MIN) begin
				cu     = {5'b0, lead_q[4:0], b[5:0]};
				lead_q = 8'h00;
				mid_q  = 8'h00;
			end else if (mid_q == 8'h00) begin
				mid_q = b;
				cu    = UNIT_ZWNBSP;
			end else begin
				cu     = {lead_q[3:0], mid_q[5:0], b[5:0]};
				lead_q = 8'h00;
				mid_q  = 8'h00;
			end
		end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
			lead_q = b;
			mid_q  = 8'h00;
			cu     = UNIT_ZWNBSP;
		end else begin
			lead_q = 8'h00;
			mid_q  = 8'h00;
		end
		if (cu == UNIT_INVALID)
			cu = UNIT_QMARK;
		if (cu == UNIT_LF) begin
			push_unit(UNIT_CR, 1'b0);
			push_unit(UNIT_LF, 1'b1);
		end else if (cu != UNIT_ZWNBSP) begin
			push_unit(cu, 1'b1);
		end
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_bytes.push_back(b);
		bytes_queued++;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// Mostly well-formed text, with specials, truncated sequences and noise
	task automatic queue_random_text(input int n_bytes);
		int target;
		int kind;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				if ($urandom_range(0, 7) == 0)
					add_byte(8'h0A);
				else
					add_byte(8'($urandom_range(0, 127)));
			end else if (kind < 55) begin
				add_byte(8'($urandom_range(8'hC2, 8'hDF)));
				add_byte(cont_byte());
			end else if (kind < 78) begin
				add_byte(8'($urandom_range(8'hE0, 8'hEF)));
				add_byte(cont_byte());
				add_byte(cont_byte());
			end else if (kind < 85) begin
				case ($urandom_range(0, 3))
					0: begin
						add_byte(8'hEF); add_byte(8'hBF); add_byte(8'hBE);
					end
					1: begin
						add_byte(8'hEF); add_byte(8'hBB); add_byte(8'hBF);
					end
					2: begin
						add_byte(8'hE0); add_byte(8'h80); add_byte(8'h8A);
					end
					default: begin
						add_byte(8'hED); add_byte(cont_byte()); add_byte(cont_byte());
					end
				endcase
			end else if (kind < 93) begin
				add_byte(8'($urandom_range(8'hC2, 8'hEF)));
				if ($urandom_range(0, 1) == 1)
					add_byte(cont_byte());
				add_byte(8'($urandom_range(0, 255)));
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Byte driver: bursts with random gaps, valid held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid   <= 1'b0;
			byte_ch.in_byte <= 8'h00;
			lead_q     = 8'h00;
			mid_q      = 8'h00;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.in_byte);
				void'(text_bytes.pop_front());
				bytes_sent++;
			end
			if (byte_ch.valid && !byte_ch.ready) begin
				input_stalls++;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
				if (gap_left > 0) begin
					byte_ch.valid <= 1'b0;
					gap_left--;
				end else if (text_bytes.size() > 0) begin
					byte_ch.valid   <= 1'b1;
					byte_ch.in_byte <= text_bytes[0];
					burst_left--;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Unit receiver: rotating stall patterns plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ch.ready <= 1'b0;
			hold_cnt = 0;
			cyc      = 0;
		end else begin
			cyc++;
			if (!long_hold_done && units_seen >= 150) begin
				hold_cnt       = 80;
				long_hold_done = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				unit_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 50) % 4)
					0: unit_ch.ready <= 1'b1;
					1: unit_ch.ready <= 1'($urandom_range(0, 1));
					2: unit_ch.ready <= (cyc % 3 == 0);
					default: unit_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Unit monitor
	always @(posedge clk) begin
		console_unit_t want;
		if (arst_n && unit_ch.valid && unit_ch.ready) begin
			units_seen <= units_seen + 1;
			if (expected_units.size() == 0) begin
				report_mismatch($sformatf("unexpected unit %h last %b",
					unit_ch.code_unit, unit_ch.last));
			end else begin
				want = expected_units.pop_front();
				if (unit_ch.code_unit !== want.code_unit)
					report_mismatch($sformatf("code_unit %h, expected %h",
						unit_ch.code_unit, want.code_unit));
				if (unit_ch.last !== want.last)
					report_mismatch($sformatf("last %b on unit %h, expected %b",
						unit_ch.last, want.code_unit, want.last));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		byte_ch.valid   = 1'b0;
		byte_ch.in_byte = 8'h00;
		unit_ch.ready   = 1'b0;
		foreach (edge_text[i])
			add_byte(edge_text[i]);
		queue_random_text(200);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sender pauses until the block has drained
		while (text_bytes.size() != 0 || expected_units.size() != 0 || byte_ch.valid)
			@(posedge clk);
		repeat (5) @(posedge clk);
		@(negedge clk);
		queue_random_text(300);

		while (text_bytes.size() != 0 || expected_units.size() != 0 || byte_ch.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d bytes (edge cases, malformed and well-formed text), %0d units.",
			bytes_sent, units_seen);
		$display("Input backpressure on %0d cycles, including one 80-cycle output hold.",
			input_stalls);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/u8u16_pkg.sv
design/u8u16_byte_if.sv
design/u8u16_unit_if.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_console_decoder.sv
tb/utf8_to_utf16_console_decoder_tb.sv
